>>> rtl/scpk_pkg.sv
// Shared constants and types for the step-compressed integer bit packer.
package scpk_pkg;

    localparam int VALUE_W_DEF   = 32;
    localparam int IN_VALUE_W    = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int BYTE_W        = 8;
    localparam int VBITS_W       = 4;
    localparam int GSEL_W        = 2;
    localparam int MAX_G         = 16;
    localparam int PEND_W        = 7;

    typedef logic [GSEL_W-1:0] t_gsel;

    localparam t_gsel GSEL_RESET = 2'd1;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_FLUSH  = 1'b1
    } t_req;

    typedef enum logic [GSEL_W-1:0] {
        GSEL_2  = 2'd0,
        GSEL_4  = 2'd1,
        GSEL_8  = 2'd2,
        GSEL_16 = 2'd3
    } t_gsize;

    // longest code over all group sizes; a partial top group still carries G bits
    function automatic int code_width(int value_w);
        int best;
        int grp_w;
        int len;
        best = 0;
        for (int s = 0; s < 4; s++) begin
            grp_w = 2 << s;
            len   = 1 + ((value_w + grp_w - 1) >> (s + 1)) * (grp_w + 1);
            if (len > best) begin
                best = len;
            end
        end
        return best;
    endfunction

endpackage

>>> rtl/scpk_if.sv
// Handshake channel interfaces: input requests, output bytes, configuration writes.
interface scpk_in_if;
    logic                                      valid;
    logic                                      ready;
    scpk_pkg::t_req                            req_type;
    logic signed [scpk_pkg::IN_VALUE_W-1:0]    value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface scpk_out_if;
    logic                          valid;
    logic                          ready;
    logic [scpk_pkg::BYTE_W-1:0]   out_byte;
    logic [scpk_pkg::VBITS_W-1:0]  valid_bits;
    logic                          last;

    modport source (output valid, output out_byte, output valid_bits, output last, input ready);
    modport sink   (input valid, input out_byte, input valid_bits, input last, output ready);
endinterface

interface scpk_cfg_if;
    logic                   valid;
    logic                   ready;
    scpk_pkg::t_gsel        data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/scpk_front.sv
// Front end: accepts requests, forms the magnitude and builds the variable-length code word.
module scpk_front #(
    parameter int VALUE_WIDTH = scpk_pkg::VALUE_W_DEF,
    parameter int CODE_W      = scpk_pkg::code_width(VALUE_WIDTH),
    parameter int LEN_W       = $clog2(CODE_W + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    scpk_in_if.sink              i_in,
    scpk_cfg_if.sink             i_cfg,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output scpk_pkg::t_req       o_q_req,
    output logic [CODE_W-1:0]    o_q_code,
    output logic [LEN_W-1:0]     o_q_len
);

    localparam int NS     = (VALUE_WIDTH + 1) >> 1;
    localparam int SLOT_W = $clog2(NS);
    localparam int CNT_W  = $clog2(NS + 1);
    localparam int EXT_W  = VALUE_WIDTH + scpk_pkg::MAX_G;
    localparam int WIDE_W = CODE_W + scpk_pkg::MAX_G + 1;

    scpk_pkg::t_gsel             r_gsel;
    logic                        r_v;
    scpk_pkg::t_req              r_req;
    logic [VALUE_WIDTH-1:0]      r_mag;
    logic                        r_pos;

    logic                        w_fire;
    logic [VALUE_WIDTH-1:0]      w_v;
    logic                        w_neg;
    logic [VALUE_WIDTH-1:0]      w_mag;
    logic [EXT_W-1:0]            w_mag_ext;
    logic [scpk_pkg::MAX_G-1:0]  w_gmask;
    logic [SLOT_W-1:0]           w_low_mask;
    logic [2:0]                  w_gsh;
    logic [NS-1:0]               w_start;
    logic [NS-1:0]               w_present;
    logic [scpk_pkg::MAX_G-1:0]  w_grp [NS];
    logic [CNT_W-1:0]            w_cnt [NS];
    logic [LEN_W-1:0]            w_off [NS];
    logic [WIDE_W-1:0]           w_seg [NS];
    logic [WIDE_W-1:0]           w_wide;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_v || i_q_ready;
    assign w_fire      = i_in.valid && i_in.ready;

    assign w_v   = i_in.value[VALUE_WIDTH-1:0];
    assign w_neg = w_v[VALUE_WIDTH-1];
    assign w_mag = w_neg ? (~w_v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : w_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsel <= scpk_pkg::GSEL_RESET;
            r_v    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_gsel <= i_cfg.data;
            end
            if (w_fire) begin
                r_v <= 1'b1;
            end else if (i_q_ready) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_req <= i_in.req_type;
            r_mag <= w_mag;
            r_pos <= !w_neg;
        end
    end

    always_comb begin
        unique case (scpk_pkg::t_gsize'(r_gsel))
            scpk_pkg::GSEL_2:  w_gmask = 16'h0003;
            scpk_pkg::GSEL_4:  w_gmask = 16'h000F;
            scpk_pkg::GSEL_8:  w_gmask = 16'h00FF;
            scpk_pkg::GSEL_16: w_gmask = 16'hFFFF;
            default:           w_gmask = 16'h000F;
        endcase
    end

    assign w_mag_ext  = {{scpk_pkg::MAX_G{1'b0}}, r_mag};
    assign w_low_mask = SLOT_W'((4'd1 << r_gsel) - 4'd1);
    assign w_gsh      = {1'b0, r_gsel} + 3'd1;

    // one slot per 2 magnitude bits; a slot opens a group when aligned to the group size
    for (genvar j = 0; j < NS; j++) begin : g_slot
        localparam logic [SLOT_W-1:0] J        = SLOT_W'(j);
        localparam logic [NS-1:0]     PRE_MASK = NS'((1 << j) - 1);

        assign w_start[j]   = (J & w_low_mask) == '0;
        assign w_grp[j]     = w_mag_ext[2*j +: scpk_pkg::MAX_G] & w_gmask;
        assign w_present[j] = w_start[j] && (w_grp[j] != '0);
        assign w_cnt[j]     = CNT_W'($countones(w_present & PRE_MASK));
        assign w_off[j]     = LEN_W'(1) + LEN_W'(J >> r_gsel)
                            + (LEN_W'(w_cnt[j]) << w_gsh);
        assign w_seg[j]     = w_present[j]
                            ? (WIDE_W'({w_grp[j], 1'b1}) << w_off[j]) : '0;
    end

    always_comb begin
        w_wide = WIDE_W'(r_pos);
        for (int j = 0; j < NS; j++) begin
            w_wide = w_wide | w_seg[j];
        end
    end

    assign o_q_valid = r_v;
    assign o_q_req   = r_req;
    assign o_q_code  = w_wide[CODE_W-1:0];
    assign o_q_len   = LEN_W'(1) + LEN_W'($countones(w_start))
                     + (LEN_W'($countones(w_present)) << w_gsh);

endmodule

>>> rtl/scpk_fifo.sv
// Small register queue between the code builder and the byte packer.
module scpk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = scpk_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WIDTH-1:0]  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WIDTH-1:0]  o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/scpk_back.sv
// Back end: merges code words with pending bits and emits bytes through an output register.
module scpk_back #(
    parameter int VALUE_WIDTH = scpk_pkg::VALUE_W_DEF,
    parameter int CODE_W      = scpk_pkg::code_width(VALUE_WIDTH),
    parameter int LEN_W       = $clog2(CODE_W + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  scpk_pkg::t_req       i_q_req,
    input  logic [CODE_W-1:0]    i_q_code,
    input  logic [LEN_W-1:0]     i_q_len,
    scpk_out_if.source           o_out
);

    localparam int ACC_W = CODE_W + scpk_pkg::PEND_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]                r_acc;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_ovalid;
    logic [scpk_pkg::BYTE_W-1:0]     r_obyte;
    logic [scpk_pkg::VBITS_W-1:0]    r_obits;
    logic                            r_olast;

    logic [ACC_W-1:0]                n_acc;
    logic [CNT_W-1:0]                n_cnt;
    logic                            w_pop;
    logic                            w_emit;
    logic [scpk_pkg::BYTE_W-1:0]     w_byte;
    logic [scpk_pkg::VBITS_W-1:0]    w_bits;
    logic                            w_last;
    logic                            w_free;
    logic                            w_full;

    assign w_free = !r_ovalid || o_out.ready;
    assign w_full = r_cnt >= CNT_W'(scpk_pkg::BYTE_W);

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        w_pop  = 1'b0;
        w_emit = 1'b0;
        w_byte = r_acc[scpk_pkg::BYTE_W-1:0];
        w_bits = scpk_pkg::VBITS_W'(scpk_pkg::BYTE_W);
        w_last = 1'b0;
        priority if (w_full) begin
            if (w_free) begin
                w_emit = 1'b1;
                w_last = r_cnt < CNT_W'(2 * scpk_pkg::BYTE_W);
                n_acc  = r_acc >> scpk_pkg::BYTE_W;
                n_cnt  = r_cnt - CNT_W'(scpk_pkg::BYTE_W);
            end
        end else if (i_q_valid) begin
            if (i_q_req == scpk_pkg::REQ_FLUSH) begin
                if (r_cnt == '0) begin
                    w_pop = 1'b1;
                end else if (w_free) begin
                    w_pop  = 1'b1;
                    w_emit = 1'b1;
                    w_byte = {1'b0, r_acc[scpk_pkg::PEND_W-1:0]};
                    w_bits = scpk_pkg::VBITS_W'(r_cnt);
                    w_last = 1'b1;
                    n_acc  = '0;
                    n_cnt  = '0;
                end
            end else begin
                w_pop = 1'b1;
                n_acc = ACC_W'(r_acc[scpk_pkg::PEND_W-1:0])
                      | (ACC_W'(i_q_code) << r_cnt[2:0]);
                n_cnt = CNT_W'(r_cnt[2:0]) + CNT_W'(i_q_len);
            end
        end
    end

    assign o_q_ready = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obyte <= w_byte;
            r_obits <= w_bits;
            r_olast <= w_last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.valid_bits = r_obits;
    assign o_out.last       = r_olast;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ACC_W))
        else $error("bit count exceeds accumulator");

    a_no_pop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_pop)
        else $error("queue popped while a full byte is pending");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_q_req == scpk_pkg::REQ_FLUSH) |=> (r_cnt == '0))
        else $error("flush left bits pending");

    a_partial_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.valid_bits != scpk_pkg::VBITS_W'(scpk_pkg::BYTE_W))
        |-> o_out.last)
        else $error("partial byte not marked last");

endmodule

>>> rtl/step_compressed_int_bit_packer.sv
// Top level of the step-compressed integer bit packer.
//
// Channels: i_in takes requests (req_type encode or flush, signed value), o_out
// delivers packed stream bytes LSB-first with valid_bits and last, i_cfg writes
// the group size select (2/4/8/16 bits, reset 4). Write i_cfg only while idle.
// A transaction completes when valid and ready are both high at a clock edge.
// The first byte of an encode request passes the front register, the queue, the
// pending-bit accumulator and the byte packer output register; a flush byte
// skips the accumulator. The packer emits one byte per cycle while the output
// is free and loads a queued request only when no full byte is pending, so it
// takes no new request before the full bytes of the last one are out.
// The input keeps accepting while the 2-entry queue has room, independent of
// the output. When the receiver stalls, the output holds its byte and the queue
// fills, then i_in.ready drops.
// Reset (synchronous, active low) empties the queue and the pending bits and
// sets the group size back to 4 bits.
module step_compressed_int_bit_packer #(
    parameter int VALUE_WIDTH = scpk_pkg::VALUE_W_DEF,
    parameter int QUEUE_DEPTH = scpk_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scpk_in_if.sink      i_in,
    scpk_out_if.source   o_out,
    scpk_cfg_if.sink     i_cfg
);

    localparam int CODE_W = scpk_pkg::code_width(VALUE_WIDTH);
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int Q_W    = 1 + CODE_W + LEN_W;

    logic                 w_f_valid;
    logic                 w_f_ready;
    scpk_pkg::t_req       w_f_req;
    logic [CODE_W-1:0]    w_f_code;
    logic [LEN_W-1:0]     w_f_len;
    logic                 w_b_valid;
    logic                 w_b_ready;
    logic [Q_W-1:0]       w_b_data;

    scpk_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CODE_W      (CODE_W),
        .LEN_W       (LEN_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .o_q_valid (w_f_valid),
        .i_q_ready (w_f_ready),
        .o_q_req   (w_f_req),
        .o_q_code  (w_f_code),
        .o_q_len   (w_f_len)
    );

    scpk_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_req, w_f_code, w_f_len}),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_data)
    );

    scpk_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CODE_W      (CODE_W),
        .LEN_W       (LEN_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_b_valid),
        .o_q_ready (w_b_ready),
        .i_q_req   (scpk_pkg::t_req'(w_b_data[Q_W-1])),
        .i_q_code  (w_b_data[LEN_W +: CODE_W]),
        .i_q_len   (w_b_data[LEN_W-1:0]),
        .o_out     (o_out)
    );

endmodule
